FILE: hw/rtl/phasor_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the phasor frame deframer
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef PHASOR_FRAME_DEFRAMER_ASSERT_SVH
`define PHASOR_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

`define PFD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define PFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PFD_ASSERT(label, clk, rstn, prop, msg)

`define PFD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// Phasor frame deframer package
// Frame layout constants, result kinds and the result record.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam logic [15:0] SYNC_RESET     = 16'hAA11;
    localparam logic [15:0] HEADER_BYTES   = 16'd25;
    localparam logic [20:0] MIN_FRAME      = 21'd27;

    localparam logic [15:0] POS_SIZE_LO    = 16'd3;
    localparam logic [15:0] POS_ID_LO      = 16'd5;
    localparam logic [15:0] POS_SOC_LO     = 16'd9;
    localparam logic [15:0] POS_FRAC_LO    = 16'd13;
    localparam logic [15:0] POS_STATUS     = 16'd14;
    localparam logic [15:0] POS_FORMAT_LO  = 16'd16;
    localparam logic [15:0] POS_PHASORS_LO = 16'd18;
    localparam logic [15:0] POS_FREQS_LO   = 16'd20;

    localparam logic [2:0] KIND_PHASOR_A  = 3'd0;
    localparam logic [2:0] KIND_PHASOR_B  = 3'd1;
    localparam logic [2:0] KIND_FREQ      = 3'd2;
    localparam logic [2:0] KIND_FREQ_RATE = 3'd3;
    localparam logic [2:0] KIND_END       = 3'd4;
    localparam logic [2:0] KIND_REJECT    = 3'd5;

    localparam logic CAUSE_SHORT   = 1'b0;
    localparam logic CAUSE_OVERRUN = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] item_index;
        logic [31:0] word;
        logic [15:0] id_code;
        logic [31:0] soc;
        logic [31:0] fraction;
        logic [7:0]  status;
        logic [15:0] format_word;
        logic [15:0] phasor_count;
        logic [15:0] frequency_count;
        logic        checksum_ok;
        logic        reject_cause;
    } res_t;

endpackage

FILE: hw/rtl/pfd_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module pfd_in_stage import pfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tready && s_tvalid) begin
            data_reg <= s_tdata;
        end
    end

endmodule

FILE: hw/rtl/pfd_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Sync hunt, header capture, payload word split and checksum, one byte a step.
// ----------------------------------------------------------------------------
module pfd_parser import pfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  logic        step,
    input  logic [7:0]  byte_in,
    output logic        res_valid,
    output res_t        res
);

    typedef enum logic [1:0] {
        PH_HUNT_EMPTY,
        PH_HUNT,
        PH_FRAME
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] sync_reg;
    logic [15:0] recent_reg, recent_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] sum_reg, sum_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] id_reg, id_next;
    logic [31:0] soc_reg, soc_next;
    logic [31:0] frac_reg, frac_next;
    logic [7:0]  status_reg, status_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] phasors_reg, phasors_next;
    logic [15:0] freqs_reg, freqs_next;
    logic [16:0] entry_reg, entry_next;
    logic [7:0]  ckhi_reg, ckhi_next;

    logic [16:0] pos_plus2;
    logic        in_body;
    logic [20:0] payload_end;
    logic [20:0] overrun_need;
    logic [16:0] two_p;
    logic [16:0] w_rest;
    logic [16:0] w_rate;
    logic        word_slot;
    logic [2:0]  kind;
    logic [15:0] item_index;
    logic [31:0] word_out;
    logic        ok;
    logic        cause;

    assign shift_next   = {shift_reg[23:0], byte_in};
    assign pos_plus2    = {1'b0, pos_reg} + 17'd2;
    assign in_body      = (pos_reg < 16'd4) || (pos_plus2 < {1'b0, size_reg});
    assign payload_end  = {5'd0, HEADER_BYTES}
                        + {1'b0, ({1'b0, phasors_reg} + {1'b0, freqs_reg}), 3'd0};
    assign overrun_need = MIN_FRAME
                        + {1'b0, ({1'b0, phasors_reg} + {1'b0, shift_next[15:0]}), 3'd0};
    assign two_p        = {phasors_reg, 1'b0};
    assign w_rest       = entry_reg - two_p;
    assign w_rate       = w_rest - {1'b0, freqs_reg};
    assign word_slot    = (pos_reg >= HEADER_BYTES) && ({5'd0, pos_reg} < payload_end)
                        && (pos_reg[1:0] == 2'd0);

    always_comb begin
        phase_next   = phase_reg;
        recent_next  = recent_reg;
        pos_next     = pos_reg;
        size_next    = size_reg;
        sum_next     = sum_reg;
        id_next      = id_reg;
        soc_next     = soc_reg;
        frac_next    = frac_reg;
        status_next  = status_reg;
        format_next  = format_reg;
        phasors_next = phasors_reg;
        freqs_next   = freqs_reg;
        entry_next   = entry_reg;
        ckhi_next    = ckhi_reg;
        res_valid    = 1'b0;
        kind         = KIND_END;
        item_index   = 16'd0;
        word_out     = 32'd0;
        ok           = 1'b0;
        cause        = CAUSE_SHORT;

        if (phase_reg != PH_FRAME) begin
            recent_next = {recent_reg[7:0], byte_in};
            if (phase_reg == PH_HUNT && recent_next == sync_reg) begin
                sum_next     = {8'd0, recent_reg[7:0]} + {8'd0, byte_in};
                pos_next     = 16'd2;
                size_next    = 16'd0;
                id_next      = 16'd0;
                soc_next     = 32'd0;
                frac_next    = 32'd0;
                status_next  = 8'd0;
                format_next  = 16'd0;
                phasors_next = 16'd0;
                freqs_next   = 16'd0;
                entry_next   = 17'd0;
                ckhi_next    = 8'd0;
                phase_next   = PH_FRAME;
            end else begin
                phase_next = PH_HUNT;
            end
        end else if (in_body) begin
            sum_next = sum_reg + {8'd0, byte_in};
            pos_next = pos_reg + 16'd1;
            unique case (pos_reg)
                POS_SIZE_LO: begin
                    size_next = shift_next[15:0];
                    if (shift_next[15:0] < MIN_FRAME[15:0]) begin
                        res_valid  = 1'b1;
                        kind       = KIND_REJECT;
                        cause      = CAUSE_SHORT;
                        phase_next = PH_HUNT_EMPTY;
                    end
                end
                POS_ID_LO:      id_next      = shift_next[15:0];
                POS_SOC_LO:     soc_next     = shift_next;
                POS_FRAC_LO:    frac_next    = shift_next;
                POS_STATUS:     status_next  = byte_in;
                POS_FORMAT_LO:  format_next  = shift_next[15:0];
                POS_PHASORS_LO: phasors_next = shift_next[15:0];
                POS_FREQS_LO: begin
                    freqs_next = shift_next[15:0];
                    if (overrun_need > {5'd0, size_reg}) begin
                        res_valid  = 1'b1;
                        kind       = KIND_REJECT;
                        cause      = CAUSE_OVERRUN;
                        phase_next = PH_HUNT_EMPTY;
                    end
                end
                default: begin
                    if (word_slot) begin
                        res_valid  = 1'b1;
                        word_out   = shift_next;
                        entry_next = entry_reg + 17'd1;
                        if (entry_reg < two_p) begin
                            kind       = entry_reg[0] ? KIND_PHASOR_B : KIND_PHASOR_A;
                            item_index = entry_reg[16:1];
                        end else if (w_rest < {1'b0, freqs_reg}) begin
                            kind       = KIND_FREQ;
                            item_index = w_rest[15:0];
                        end else begin
                            kind       = KIND_FREQ_RATE;
                            item_index = w_rate[15:0];
                        end
                    end
                end
            endcase
        end else if (pos_plus2 == {1'b0, size_reg}) begin
            ckhi_next = byte_in;
            pos_next  = pos_reg + 16'd1;
        end else begin
            res_valid  = 1'b1;
            kind       = KIND_END;
            ok         = ({ckhi_reg, byte_in} == sum_reg);
            phase_next = PH_HUNT_EMPTY;
        end
    end

    always_comb begin
        res.kind            = kind;
        res.item_index      = item_index;
        res.word            = word_out;
        res.id_code         = id_next;
        res.soc             = soc_next;
        res.fraction        = frac_next;
        res.status          = status_next;
        res.format_word     = format_next;
        res.phasor_count    = phasors_next;
        res.frequency_count = freqs_next;
        res.checksum_ok     = ok;
        res.reject_cause    = cause;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= SYNC_RESET;
            phase_reg   <= PH_HUNT_EMPTY;
            recent_reg  <= 16'd0;
            pos_reg     <= 16'd0;
            size_reg    <= 16'd0;
            sum_reg     <= 16'd0;
            shift_reg   <= 32'd0;
            id_reg      <= 16'd0;
            soc_reg     <= 32'd0;
            frac_reg    <= 32'd0;
            status_reg  <= 8'd0;
            format_reg  <= 16'd0;
            phasors_reg <= 16'd0;
            freqs_reg   <= 16'd0;
            entry_reg   <= 17'd0;
            ckhi_reg    <= 8'd0;
        end else begin
            if (cfg_valid) begin
                sync_reg <= cfg_data;
            end
            if (step) begin
                phase_reg   <= phase_next;
                recent_reg  <= recent_next;
                pos_reg     <= pos_next;
                size_reg    <= size_next;
                sum_reg     <= sum_next;
                shift_reg   <= (phase_reg == PH_FRAME) ? shift_next :
                               ((phase_next == PH_FRAME) ? 32'd0 : shift_reg);
                id_reg      <= id_next;
                soc_reg     <= soc_next;
                frac_reg    <= frac_next;
                status_reg  <= status_next;
                format_reg  <= format_next;
                phasors_reg <= phasors_next;
                freqs_reg   <= freqs_next;
                entry_reg   <= entry_next;
                ckhi_reg    <= ckhi_next;
            end
        end
    end

endmodule

FILE: hw/rtl/phasor_frame_deframer.sv
// ----------------------------------------------------------------------------
// Path: a byte accepted on s_ is held in the input register; the parser steps on it
// when the result register is empty or m_tready is high, and loads the result register.
// Throughput: one byte per cycle while m_tready does not stall the result register,
// set by the single parser pass between the input register and the result register.
// Reset: synchronous aresetn clears all parser state, empties both registers
// and returns the sync pattern to 0xAA11.
// ----------------------------------------------------------------------------
// Phasor frame deframer
// Byte stream in, payload words and frame summaries out.
// ----------------------------------------------------------------------------
`include "phasor_frame_deframer_assert.svh"

module phasor_frame_deframer import pfd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // item_index, word, id_code, soc, fraction, status,
                                    // format_word, phasor_count, frequency_count,
                                    // checksum_ok, reject_cause, zero fill
    output logic [2:0]   m_tuser    // kind
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       take;
    logic       res_valid;
    res_t       res;

    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg;

    assign cfg_ready = 1'b1;
    assign take      = byte_valid && (!out_valid_reg || m_tready);

    pfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    pfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step      (take),
        .byte_in   (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (take && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {6'd0,
                       out_res_reg.reject_cause,
                       out_res_reg.checksum_ok,
                       out_res_reg.frequency_count,
                       out_res_reg.phasor_count,
                       out_res_reg.format_word,
                       out_res_reg.status,
                       out_res_reg.fraction,
                       out_res_reg.soc,
                       out_res_reg.id_code,
                       out_res_reg.word,
                       out_res_reg.item_index};

    `PFD_ASSERT(a_byte_held, aclk, aresetn,
        (byte_valid && !take) |=> byte_valid, "input byte dropped")
    `PFD_ASSERT(a_ok_only_end, aclk, aresetn,
        (m_tvalid && m_tuser != KIND_END) |-> !m_tdata[184], "checksum flag outside frame end")
    `PFD_ASSERT(a_cause_only_reject, aclk, aresetn,
        (m_tvalid && m_tuser != KIND_REJECT) |-> !m_tdata[185], "reject cause outside reject")
    `PFD_ASSERT(a_no_take_when_full, aclk, aresetn,
        (out_valid_reg && !m_tready) |-> !take, "parser stepped into a full result register")

endmodule
